// ===== sv/priority_quantum_scheduler_defines.svh =====
// Assertion macros shared by the priority quantum scheduler RTL.
`ifndef PRIORITY_QUANTUM_SCHEDULER_DEFINES_SVH
`define PRIORITY_QUANTUM_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and masked during reset.
`define PQS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk and masked during reset.
`define PQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PQS_ASSERT_IMP(lbl, ante, cons, msg)
`define PQS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/pqs_pkg.sv =====
// Types, codes and helpers shared by the priority quantum scheduler modules.
package pqs_pkg;

	// Table size and the widths that follow from it.
	localparam int MAX_PROC = 64;
	localparam int IDX_W    = $clog2(MAX_PROC);
	localparam int CNT_W    = $clog2(MAX_PROC + 1);
	localparam int PNUM_W   = 7;

	// Input word modes.
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_STEP  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// Result word event codes.
	localparam logic [2:0] EV_LOADED   = 3'd0;
	localparam logic [2:0] EV_SLICE    = 3'd1;
	localparam logic [2:0] EV_IDLE     = 3'd2;
	localparam logic [2:0] EV_ALL_DONE = 3'd3;
	localparam logic [2:0] EV_REJECT   = 3'd4;

	// Configuration port.
	localparam int          CFG_ADDR_W    = 3;
	localparam logic [CFG_ADDR_W-3:0] REG_QUANTUM = '0;
	localparam logic [15:0] QUANTUM_RESET = 16'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        burst_time;
		logic signed [15:0] priority_level;
		logic [15:0]        ready_time;
	} in_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [6:0]  process_number;
		logic [15:0] slice_length;
		logic [15:0] remaining_burst;
		logic [31:0] time_now;
		logic        finished;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic [31:0] response;
		logic [39:0] sum_turnaround;
		logic [39:0] sum_waiting;
		logic [39:0] sum_response;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic load;
		logic clear;
		logic res_all_done;
		logic scan_start;
		logic scan_issue;
		logic exec;
		logic idle_tick;
		logic turn;
		logic wait_sum;
		logic sums;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic all_done;
		logic scan_last;
		logic found;
		logic slice_done;
	} sts_t;

	// Saturating 40-bit accumulate of a 32-bit amount.
	function automatic logic [39:0] sat_add40(input logic [39:0] a, input logic [31:0] b);
		logic [40:0] s;
		s = {1'b0, a} + 41'(b);
		return s[40] ? '1 : s[39:0];
	endfunction

endpackage

// ===== sv/pqs_ctrl.sv =====
// Sequencing state machine of the priority quantum scheduler.
module pqs_ctrl import pqs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] item_mode,
	output logic       item_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_CLEAR = 4'd2;
	localparam logic [3:0] S_STEP  = 4'd3;
	localparam logic [3:0] S_SCAN  = 4'd4;
	localparam logic [3:0] S_DRAIN = 4'd5;
	localparam logic [3:0] S_PICK  = 4'd6;
	localparam logic [3:0] S_TURN  = 4'd7;
	localparam logic [3:0] S_WAITS = 4'd8;
	localparam logic [3:0] S_SUMS  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       valid_q;

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					unique case (item_mode)
						MODE_LOAD:  state_d = S_LOAD;
						MODE_STEP:  state_d = S_STEP;
						MODE_CLEAR: state_d = S_CLEAR;
						MODE_NONE:  state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_OUT;
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = S_OUT;
			end
			S_STEP: begin
				if (sts.all_done) begin
					cmd.res_all_done = 1'b1;
					state_d          = S_OUT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_PICK;
			end
			S_PICK: begin
				if (sts.found) begin
					cmd.exec = 1'b1;
					state_d  = sts.slice_done ? S_TURN : S_OUT;
				end else begin
					cmd.idle_tick = 1'b1;
					state_d       = S_OUT;
				end
			end
			S_TURN: begin
				cmd.turn = 1'b1;
				state_d  = S_WAITS;
			end
			S_WAITS: begin
				cmd.wait_sum = 1'b1;
				state_d      = S_SUMS;
			end
			S_SUMS: begin
				cmd.sums = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (!valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output word valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = valid_q;

endmodule

// ===== sv/pqs_dp.sv =====
// Process table, scan pipeline, slice arithmetic and totals of the scheduler.
module pqs_dp import pqs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  in_t         item,
	input  logic [15:0] quantum,
	output out_t        result
);

	typedef struct packed {
		logic [31:0] first_resp;
		logic [15:0] remaining;
		logic [15:0] orig;
		logic [15:0] prio;
		logic [15:0] arrival;
	} entry_t;

	// Table memory: one write port, one registered read port.
	entry_t mem [MAX_PROC];

	in_t                item_q;
	logic [CNT_W-1:0]   loaded_q;
	logic [CNT_W-1:0]   done_cnt_q;
	logic [31:0]        clock_q;
	logic [39:0]        sum_turn_q;
	logic [39:0]        sum_wait_q;
	logic [39:0]        sum_resp_q;
	logic [MAX_PROC-1:0] done_flags_q;
	logic [MAX_PROC-1:0] started_q;
	logic [IDX_W-1:0]   scan_cnt_q;
	entry_t             rd_s1;
	logic               rd_v_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	entry_t             best_q;
	logic [31:0]        turn_q;
	logic [31:0]        wait_q;
	logic [31:0]        resp_q;
	logic [2:0]         res_kind_q;
	logic [PNUM_W-1:0]  res_pnum_q;
	logic [15:0]        res_slice_q;
	logic [15:0]        res_rem_q;
	logic               res_fin_q;
	out_t               out_q;

	logic               load_ok;
	logic               cand_ok;
	logic [15:0]        q_eff;
	logic [15:0]        slice;
	logic [15:0]        rem_new;
	logic [32:0]        clock_sum;
	logic [31:0]        clock_new;
	logic [31:0]        resp_new;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	entry_t             mem_wd;

	// A load needs a nonzero burst and a free slot.
	assign load_ok = (item_q.burst_time != 16'd0) && (loaded_q < CNT_W'(MAX_PROC));

	// Candidate test on the entry read in the previous cycle.
	assign cand_ok = rd_v_s1 && !done_flags_q[rd_idx_s1] && (rd_s1.remaining != 16'd0) &&
		(32'(rd_s1.arrival) <= clock_q) &&
		(!found_q || ($signed(rd_s1.prio) > $signed(best_q.prio)));

	// Slice of the chosen entry and the clock after it.
	assign q_eff     = (quantum == 16'd0) ? 16'd1 : quantum;
	assign slice     = (best_q.remaining < q_eff) ? best_q.remaining : q_eff;
	assign rem_new   = best_q.remaining - slice;
	assign clock_sum = {1'b0, clock_q} + 33'(slice);
	assign clock_new = clock_sum[32] ? '1 : clock_sum[31:0];
	assign resp_new  = clock_q - 32'(best_q.arrival);

	// Write port: new entry on a load, updated entry on a slice.
	always_comb begin
		mem_we = (cmd.load && load_ok) || cmd.exec;
		if (cmd.exec) begin
			mem_wa           = best_idx_q;
			mem_wd           = best_q;
			mem_wd.remaining = rem_new;
			mem_wd.first_resp = started_q[best_idx_q] ? best_q.first_resp : resp_new;
		end else begin
			mem_wa = loaded_q[IDX_W-1:0];
			mem_wd = '{first_resp: 32'd0, remaining: item_q.burst_time,
				orig: item_q.burst_time, prio: item_q.priority_level,
				arrival: item_q.ready_time};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.scan_issue) begin
			rd_s1 <= mem[scan_cnt_q];
		end
	end

	// Counters, clock, totals and per-entry flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q     <= '0;
			done_cnt_q   <= '0;
			clock_q      <= '0;
			sum_turn_q   <= '0;
			sum_wait_q   <= '0;
			sum_resp_q   <= '0;
			done_flags_q <= '0;
			started_q    <= '0;
			scan_cnt_q   <= '0;
			rd_v_s1      <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_issue;
			if (cmd.clear) begin
				loaded_q     <= '0;
				done_cnt_q   <= '0;
				clock_q      <= '0;
				sum_turn_q   <= '0;
				sum_wait_q   <= '0;
				sum_resp_q   <= '0;
				done_flags_q <= '0;
				started_q    <= '0;
			end
			if (cmd.load && load_ok) begin
				loaded_q                         <= loaded_q + CNT_W'(1);
				done_flags_q[loaded_q[IDX_W-1:0]] <= 1'b0;
				started_q[loaded_q[IDX_W-1:0]]    <= 1'b0;
			end
			if (cmd.scan_start) begin
				scan_cnt_q <= '0;
				found_q    <= 1'b0;
			end
			if (cmd.scan_issue) begin
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end
			if (cand_ok) begin
				found_q <= 1'b1;
			end
			if (cmd.exec) begin
				clock_q               <= clock_new;
				started_q[best_idx_q] <= 1'b1;
				if (rem_new == 16'd0) begin
					done_flags_q[best_idx_q] <= 1'b1;
					done_cnt_q               <= done_cnt_q + CNT_W'(1);
				end
			end
			if (cmd.idle_tick && (clock_q != '1)) begin
				clock_q <= clock_q + 32'd1;
			end
			if (cmd.wait_sum) begin
				sum_turn_q <= sat_add40(sum_turn_q, turn_q);
			end
			if (cmd.sums) begin
				sum_wait_q <= sat_add40(sum_wait_q, wait_q);
				sum_resp_q <= sat_add40(sum_resp_q, resp_q);
			end
		end
	end

	// Input word, best candidate, completion figures and result fields.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
		rd_idx_s1 <= scan_cnt_q;
		if (cand_ok) begin
			best_idx_q <= rd_idx_s1;
			best_q     <= rd_s1;
		end
		if (cmd.exec) begin
			resp_q <= started_q[best_idx_q] ? best_q.first_resp : resp_new;
		end
		if (cmd.turn) begin
			turn_q <= clock_q - 32'(best_q.arrival);
		end
		if (cmd.wait_sum) begin
			wait_q <= (turn_q >= 32'(best_q.orig)) ? (turn_q - 32'(best_q.orig)) : '0;
		end
		if (cmd.load) begin
			res_kind_q  <= load_ok ? EV_LOADED : EV_REJECT;
			res_pnum_q  <= load_ok ? PNUM_W'(loaded_q + CNT_W'(1)) : '0;
			res_slice_q <= '0;
			res_rem_q   <= '0;
			res_fin_q   <= 1'b0;
		end
		if (cmd.clear || cmd.res_all_done || cmd.idle_tick) begin
			priority if (cmd.clear) begin
				res_kind_q <= EV_LOADED;
			end else if (cmd.res_all_done) begin
				res_kind_q <= EV_ALL_DONE;
			end else begin
				res_kind_q <= EV_IDLE;
			end
			res_pnum_q  <= '0;
			res_slice_q <= '0;
			res_rem_q   <= '0;
			res_fin_q   <= 1'b0;
		end
		if (cmd.exec) begin
			res_kind_q  <= EV_SLICE;
			res_pnum_q  <= PNUM_W'(CNT_W'(best_idx_q) + CNT_W'(1));
			res_slice_q <= slice;
			res_rem_q   <= rem_new;
			res_fin_q   <= (rem_new == 16'd0);
		end
		if (cmd.out_load) begin
			out_q.event_kind      <= res_kind_q;
			out_q.process_number  <= res_pnum_q;
			out_q.slice_length    <= res_slice_q;
			out_q.remaining_burst <= res_rem_q;
			out_q.time_now        <= clock_q;
			out_q.finished        <= res_fin_q;
			out_q.turnaround      <= res_fin_q ? turn_q : '0;
			out_q.waiting         <= res_fin_q ? wait_q : '0;
			out_q.response        <= res_fin_q ? resp_q : '0;
			out_q.sum_turnaround  <= sum_turn_q;
			out_q.sum_waiting     <= sum_wait_q;
			out_q.sum_response    <= sum_resp_q;
		end
	end

	// Status to the controller.
	assign sts.all_done   = (done_cnt_q >= loaded_q);
	assign sts.scan_last  = ((CNT_W'(scan_cnt_q) + CNT_W'(1)) == loaded_q);
	assign sts.found      = found_q;
	assign sts.slice_done = (rem_new == 16'd0);

	assign result = out_q;

endmodule

// ===== sv/priority_quantum_scheduler.sv =====
// Top level of the priority quantum scheduler: register port, controller and datapath.
//
//   port group      direction  contents
//   item_*          in         load, step or clear word (valid/ready)
//   result_*        out        one result word per load, step or clear (valid/ready)
//   p*              in/out     APB-style register port, time_quantum at 0x0
//
// A load or clear word goes from its own state to the output state. A step word
// scans the loaded entries, then slices the best one, with turnaround, waiting and
// sums states if it finishes; the scan reads one table entry per cycle through the
// single read port of the table memory. A step with nothing left skips the scan.
// Reset clears the counters, clock, totals and flags; the table contents are not cleared.
// A stalled result word holds in its output register while the next word is taken.
`include "priority_quantum_scheduler_defines.svh"
module priority_quantum_scheduler import pqs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  in_t                   item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output out_t                  result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic        quantum_q;
	logic [15:0] quantum_val_q;
	logic        cfg_hit;
	cmd_t        cmd;
	sts_t        sts;

	// Register port: time_quantum is the only register.
	assign pready  = 1'b1;
	assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_QUANTUM);
	assign prdata  = cfg_hit ? {16'd0, quantum_val_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_val_q <= QUANTUM_RESET;
			quantum_q     <= 1'b0;
		end else begin
			quantum_q <= 1'b0;
			if (psel && penable && pwrite && pready && cfg_hit) begin
				quantum_val_q <= pwdata[15:0];
				quantum_q     <= 1'b1;
			end
		end
	end

	pqs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_mode    (item.mode),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	pqs_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.item    (item),
		.quantum (quantum_val_q),
		.result  (result)
	);

	// The user must write a register only while no word is in flight; the block does not enforce it.
	`PQS_ASSERT_IMP(a_cfg_write_idle, quantum_q, item_ready, "quantum written while busy")
	// An accepted load, step or clear word makes the block busy.
	`PQS_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready && item.mode != MODE_NONE, !item_ready, "block still ready after accepting a word")
	// Only an executed slice can finish a process, and it leaves nothing behind.
	`PQS_ASSERT_IMP(a_finish_is_slice, result_valid && result.finished, result.event_kind == EV_SLICE && result.remaining_burst == 16'd0, "finish flag on a word that is not a completed slice")
	// An executed slice always runs for at least one time unit.
	`PQS_ASSERT_IMP(a_slice_nonzero, result_valid && result.event_kind == EV_SLICE, result.slice_length != 16'd0, "empty slice reported")

endmodule
